// File: design/pol_pkg.sv
// ----------------------------------------------------------------------------
// pol_pkg: shared definitions for the positional ordered list
// Sizes, operation and status codes, cell command codes and the control
// word that the top level broadcasts to every cell of the chain.
// ----------------------------------------------------------------------------
package pol_pkg;

	// list size and derived widths
	localparam int CAPACITY = 16;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int POS_W    = 5;
	localparam int VAL_W    = 32;
	localparam int CMP_W    = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

	// operation codes
	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_DELETE = 2'd1;
	localparam logic [1:0] OP_DUMP   = 2'd2;

	// status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_BADPOS = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;
	localparam logic [1:0] ST_EMPTY  = 2'd3;

	// cell commands
	localparam logic [1:0] CMD_HOLD   = 2'd0;
	localparam logic [1:0] CMD_INSERT = 2'd1;
	localparam logic [1:0] CMD_DELETE = 2'd2;
	localparam logic [1:0] CMD_ROTATE = 2'd3;

	// control word broadcast to the chain
	typedef struct packed {
		logic [1:0]       cmd;
		logic [IDX_W-1:0] sel_idx;
		logic [IDX_W-1:0] last_idx;
	} pol_ctrl_t;

endpackage

// File: design/pol_cell.sv
// ----------------------------------------------------------------------------
// pol_cell: one storage cell of the list chain
// Holds one element and, per the broadcast command, keeps it, takes the
// left neighbor (insert shift), the right neighbor (delete shift or rotate),
// the new word (insert slot) or the head word (rotate wrap).
// ----------------------------------------------------------------------------
module pol_cell (
	input  logic                      clk,
	input  logic [pol_pkg::IDX_W-1:0] idx,
	input  pol_pkg::pol_ctrl_t        ctrl,
	input  logic [pol_pkg::VAL_W-1:0] new_word,
	input  logic [pol_pkg::VAL_W-1:0] left_word,
	input  logic [pol_pkg::VAL_W-1:0] right_word,
	input  logic [pol_pkg::VAL_W-1:0] head_word,
	output logic [pol_pkg::VAL_W-1:0] data
);

	logic [pol_pkg::VAL_W-1:0] data_q;
	logic [pol_pkg::VAL_W-1:0] data_d;

	// pick the next word for this cell
	always_comb begin
		data_d = data_q;
		unique case (ctrl.cmd)
			pol_pkg::CMD_INSERT: begin
				if (idx == ctrl.sel_idx) begin
					data_d = new_word;
				end else if (idx > ctrl.sel_idx) begin
					data_d = left_word;
				end
			end
			pol_pkg::CMD_DELETE: begin
				if (idx >= ctrl.sel_idx) begin
					data_d = right_word;
				end
			end
			pol_pkg::CMD_ROTATE: begin
				if (idx == ctrl.last_idx) begin
					data_d = head_word;
				end else begin
					data_d = right_word;
				end
			end
			default: data_d = data_q;
		endcase
	end

	// store the element
	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data = data_q;

endmodule

// File: design/positional_ordered_list.sv
// ----------------------------------------------------------------------------
// positional_ordered_list: bounded ordered list of signed 32-bit values
// Insert, delete and dump by 1-based position over a chain of storage cells.
// ----------------------------------------------------------------------------
// An insert or delete gives a single result word, which shows
// on the outputs, marked by valid, in the cycle after acceptance; busy stays
// low, so such commands may be issued every cycle. A dump of N stored
// elements gives N result words on consecutive cycles, starting the cycle
// after acceptance, with last_of_run on the final one; busy is high after
// acceptance while the cell chain rotates by one cell per cycle to bring
// each element to the head. A dump of an empty list gives one word with
// status 3. Results cannot be held off: capture each word in the
// cycle that valid is high.
module positional_ordered_list (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [1:0]                       op,
	input  logic [pol_pkg::POS_W-1:0]        position,
	input  logic signed [pol_pkg::VAL_W-1:0] value,
	output logic                             valid,
	output logic [1:0]                       status,
	output logic [4:0]                       element_count,
	output logic signed [pol_pkg::VAL_W-1:0] element_value,
	output logic                             is_listing,
	output logic                             last_of_run
);

	logic                      accept;
	logic [pol_pkg::CNT_W-1:0] cnt_q;
	logic [pol_pkg::CNT_W-1:0] cnt_d;
	logic [pol_pkg::CNT_W-1:0] rem_q;
	logic                      dumping_q;
	logic [pol_pkg::CMP_W-1:0] pos_x;
	logic [pol_pkg::CMP_W-1:0] cnt_x;
	logic [pol_pkg::CMP_W-1:0] pos_m1;
	logic [pol_pkg::CMP_W-1:0] cnt_m1;
	logic                      ins_bad;
	logic                      ins_full;
	logic                      ins_ok;
	logic                      del_empty;
	logic                      del_bad;
	logic                      del_ok;
	logic                      dump_start;
	pol_pkg::pol_ctrl_t        ctrl;
	logic [pol_pkg::VAL_W-1:0] cell_data  [pol_pkg::CAPACITY];
	logic [pol_pkg::VAL_W-1:0] left_data  [pol_pkg::CAPACITY];
	logic [pol_pkg::VAL_W-1:0] right_data [pol_pkg::CAPACITY];

	logic                      valid_q;
	logic [1:0]                status_q;
	logic [pol_pkg::CNT_W-1:0] count_q;
	logic [pol_pkg::VAL_W-1:0] value_q;
	logic                      listing_q;
	logic                      last_q;

	assign busy   = dumping_q;
	assign accept = start && !busy;

	// range checks against the current count
	assign pos_x     = pol_pkg::CMP_W'(position);
	assign cnt_x     = pol_pkg::CMP_W'(cnt_q);
	assign pos_m1    = pos_x - pol_pkg::CMP_W'(1);
	assign cnt_m1    = cnt_x - pol_pkg::CMP_W'(1);
	assign ins_bad   = (position == '0) || (pos_x > (cnt_x + pol_pkg::CMP_W'(1)));
	assign ins_full  = (cnt_q == pol_pkg::CNT_W'(pol_pkg::CAPACITY));
	assign ins_ok    = accept && (op == pol_pkg::OP_INSERT) && !ins_bad && !ins_full;
	assign del_empty = (cnt_q == '0);
	assign del_bad   = (position == '0) || (pos_x > cnt_x);
	assign del_ok    = accept && (op == pol_pkg::OP_DELETE) && !del_empty && !del_bad;
	assign dump_start = accept && (op == pol_pkg::OP_DUMP) && !del_empty;

	// broadcast the cell command
	always_comb begin
		ctrl.sel_idx  = pos_m1[pol_pkg::IDX_W-1:0];
		ctrl.last_idx = cnt_m1[pol_pkg::IDX_W-1:0];
		if (ins_ok) begin
			ctrl.cmd = pol_pkg::CMD_INSERT;
		end else if (del_ok) begin
			ctrl.cmd = pol_pkg::CMD_DELETE;
		end else if (dump_start || dumping_q) begin
			ctrl.cmd = pol_pkg::CMD_ROTATE;
		end else begin
			ctrl.cmd = pol_pkg::CMD_HOLD;
		end
	end

	// next element count
	always_comb begin
		cnt_d = cnt_q;
		if (ins_ok) begin
			cnt_d = cnt_q + pol_pkg::CNT_W'(1);
		end else if (del_ok) begin
			cnt_d = cnt_q - pol_pkg::CNT_W'(1);
		end
	end

	// cell chain
	for (genvar g = 0; g < pol_pkg::CAPACITY; g++) begin : g_cell
		if (g == 0) begin : g_first
			assign left_data[g] = '0;
		end else begin : g_mid_l
			assign left_data[g] = cell_data[g-1];
		end
		if (g == pol_pkg::CAPACITY - 1) begin : g_last
			assign right_data[g] = cell_data[g];
		end else begin : g_mid_r
			assign right_data[g] = cell_data[g+1];
		end

		pol_cell u_cell (
			.clk        (clk),
			.idx        (pol_pkg::IDX_W'(g)),
			.ctrl       (ctrl),
			.new_word   (value),
			.left_word  (left_data[g]),
			.right_word (right_data[g]),
			.head_word  (cell_data[0]),
			.data       (cell_data[g])
		);
	end

	// count and dump control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			rem_q     <= '0;
			dumping_q <= 1'b0;
			valid_q   <= 1'b0;
		end else begin
			cnt_q   <= cnt_d;
			valid_q <= accept || dumping_q;
			if (dump_start) begin
				rem_q     <= cnt_q - pol_pkg::CNT_W'(1);
				dumping_q <= (cnt_q != pol_pkg::CNT_W'(1));
			end else if (dumping_q) begin
				rem_q     <= rem_q - pol_pkg::CNT_W'(1);
				dumping_q <= (rem_q != pol_pkg::CNT_W'(1));
			end
		end
	end

	// result word
	always_ff @(posedge clk) begin
		count_q <= cnt_d;
		if (dump_start || dumping_q) begin
			status_q  <= pol_pkg::ST_OK;
			value_q   <= cell_data[0];
			listing_q <= 1'b1;
			last_q    <= dumping_q ? (rem_q == pol_pkg::CNT_W'(1))
			                       : (cnt_q == pol_pkg::CNT_W'(1));
		end else begin
			value_q   <= '0;
			listing_q <= 1'b0;
			last_q    <= 1'b1;
			unique case (op)
				pol_pkg::OP_INSERT: begin
					if (ins_bad) begin
						status_q <= pol_pkg::ST_BADPOS;
					end else if (ins_full) begin
						status_q <= pol_pkg::ST_FULL;
					end else begin
						status_q <= pol_pkg::ST_OK;
					end
				end
				pol_pkg::OP_DELETE: begin
					if (del_empty) begin
						status_q <= pol_pkg::ST_EMPTY;
					end else if (del_bad) begin
						status_q <= pol_pkg::ST_BADPOS;
					end else begin
						status_q <= pol_pkg::ST_OK;
					end
				end
				pol_pkg::OP_DUMP: status_q <= pol_pkg::ST_EMPTY;
				default:          status_q <= pol_pkg::ST_BADPOS;
			endcase
		end
	end

	assign valid         = valid_q;
	assign status        = status_q;
	assign element_count = 5'(count_q);
	assign element_value = value_q;
	assign is_listing    = listing_q;
	assign last_of_run   = last_q;

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= pol_pkg::CNT_W'(pol_pkg::CAPACITY))
		else $error("element count above capacity");

	a_rem_live: assert property (@(posedge clk) disable iff (!arst_n)
		dumping_q |-> (rem_q != '0))
		else $error("dump running with nothing left");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !listing_q) |-> last_q)
		else $error("non-listing word not marked last");

	a_ins_count: assert property (@(posedge clk) disable iff (!arst_n)
		ins_ok |=> (cnt_q == $past(cnt_q) + pol_pkg::CNT_W'(1)))
		else $error("insert did not grow the list");

	a_dump_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(dumping_q) |-> (valid_q && last_q && listing_q))
		else $error("dump ended without a last word");
`endif

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the positional ordered list
// Drives insert, delete and dump commands through the start/busy handshake,
// predicts every result word from a shadow copy of the list, and checks each
// word on the valid strobe field by field. Directed corner cases come first,
// then random traffic that swings the list between empty and full under
// several sender idle rates.
// ----------------------------------------------------------------------------
module tb;

	// op code that the block does not define
	localparam logic [1:0] OP_UNUSED = 2'd3;

	logic                             clk;
	logic                             arst_n;
	logic                             start;
	logic                             busy;
	logic [1:0]                       op;
	logic [pol_pkg::POS_W-1:0]        position;
	logic signed [pol_pkg::VAL_W-1:0] value;
	logic                             valid;
	logic [1:0]                       status;
	logic [4:0]                       element_count;
	logic signed [pol_pkg::VAL_W-1:0] element_value;
	logic                             is_listing;
	logic                             last_of_run;

	// shadow list, queue of predicted result words and mismatch count
	class list_scoreboard;
		typedef struct {
			logic [1:0]                       status;
			logic [4:0]                       count;
			logic signed [pol_pkg::VAL_W-1:0] value;
			logic                             listing;
			logic                             last;
		} list_word_t;

		logic signed [pol_pkg::VAL_W-1:0] cells[pol_pkg::CAPACITY];
		int                               held;
		list_word_t                       wanted_q[$];
		int                               fail_count;

		function new();
			held = 0;
			fail_count = 0;
		endfunction

		// queue one predicted word, count taken after the operation
		function void push_word(logic [1:0] st, logic signed [pol_pkg::VAL_W-1:0] v,
					logic listing, logic last);
			list_word_t w;
			w.status  = st;
			w.count   = held[4:0];
			w.value   = v;
			w.listing = listing;
			w.last    = last;
			wanted_q.push_back(w);
		endfunction

		// apply an accepted command word to the shadow list
		function void note_input(logic [1:0] cmd, logic [pol_pkg::POS_W-1:0] pos,
					 logic signed [pol_pkg::VAL_W-1:0] v);
			int p;
			int i;
			p = pos;
			case (cmd)
				pol_pkg::OP_INSERT: begin
					if (p == 0 || p > held + 1)
						push_word(pol_pkg::ST_BADPOS, '0, 1'b0, 1'b1);
					else if (held >= pol_pkg::CAPACITY)
						push_word(pol_pkg::ST_FULL, '0, 1'b0, 1'b1);
					else begin
						for (i = held; i >= p; i--)
							cells[i] = cells[i-1];
						cells[p-1] = v;
						held++;
						push_word(pol_pkg::ST_OK, '0, 1'b0, 1'b1);
					end
				end
				pol_pkg::OP_DELETE: begin
					if (held == 0)
						push_word(pol_pkg::ST_EMPTY, '0, 1'b0, 1'b1);
					else if (p == 0 || p > held)
						push_word(pol_pkg::ST_BADPOS, '0, 1'b0, 1'b1);
					else begin
						for (i = p - 1; i + 1 < held; i++)
							cells[i] = cells[i+1];
						held--;
						push_word(pol_pkg::ST_OK, '0, 1'b0, 1'b1);
					end
				end
				pol_pkg::OP_DUMP: begin
					if (held == 0)
						push_word(pol_pkg::ST_EMPTY, '0, 1'b0, 1'b1);
					else
						for (i = 0; i < held; i++)
							push_word(pol_pkg::ST_OK, cells[i], 1'b1, (i + 1 == held));
				end
				default: push_word(pol_pkg::ST_BADPOS, '0, 1'b0, 1'b1);
			endcase
		endfunction

		task report_mismatch(string what);
			$display("[%0t] MISMATCH: %s", $realtime, what);
			fail_count++;
		endtask

		// compare one result word against the oldest prediction
		task check_result(logic [1:0] st, logic [4:0] cnt,
				  logic signed [pol_pkg::VAL_W-1:0] v,
				  logic listing, logic last);
			list_word_t w;
			if (wanted_q.size() == 0) begin
				report_mismatch($sformatf("unexpected word status=%0d count=%0d",
					st, cnt));
				return;
			end
			w = wanted_q.pop_front();
			if (st !== w.status)
				report_mismatch($sformatf("status %0d, want %0d", st, w.status));
			if (cnt !== w.count)
				report_mismatch($sformatf("element_count %0d, want %0d", cnt, w.count));
			if (v !== w.value)
				report_mismatch($sformatf("element_value %0d, want %0d", v, w.value));
			if (listing !== w.listing)
				report_mismatch($sformatf("is_listing %0b, want %0b", listing, w.listing));
			if (last !== w.last)
				report_mismatch($sformatf("last_of_run %0b, want %0b", last, w.last));
		endtask
	endclass

	list_scoreboard sb = new();

	positional_ordered_list i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.op           (op),
		.position     (position),
		.value        (value),
		.valid        (valid),
		.status       (status),
		.element_count(element_count),
		.element_value(element_value),
		.is_listing   (is_listing),
		.last_of_run  (last_of_run)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// run limit
	initial begin
		#4000000;
		$display("Test completed with failures");
		$finish;
	end

	// check every result word on its strobe
	always @(posedge clk) begin
		if (arst_n && valid)
			sb.check_result(status, element_count, element_value, is_listing,
					last_of_run);
	end

	// present one command word, idle first at random, hold until accepted
	task automatic send_word(logic [1:0] cmd, logic [pol_pkg::POS_W-1:0] pos,
				 logic signed [pol_pkg::VAL_W-1:0] v, int idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start    <= 1'b1;
		op       <= cmd;
		position <= pos;
		value    <= v;
		do
			@(posedge clk);
		while (busy);
		sb.note_input(cmd, pos, v);
	endtask

	// random traffic, alternating between filling and draining the list
	task automatic run_random(int words, int idle_pct);
		int                        k;
		int                        r;
		bit                        filling;
		logic [1:0]                cmd;
		logic [pol_pkg::POS_W-1:0] pos;
		for (k = 0; k < words; k++) begin
			filling = ((k / 30) % 2) == 0;
			r = $urandom_range(99);
			if (r < 4)
				cmd = OP_UNUSED;
			else if (r < 16)
				cmd = pol_pkg::OP_DUMP;
			else if ($urandom_range(99) < (filling ? 80 : 25))
				cmd = pol_pkg::OP_INSERT;
			else
				cmd = pol_pkg::OP_DELETE;
			// mostly legal positions, some drawn from the whole field
			if ($urandom_range(99) < 20 || sb.held == 0 && cmd == pol_pkg::OP_DELETE)
				pos = pol_pkg::POS_W'($urandom_range(31));
			else if (cmd == pol_pkg::OP_INSERT)
				pos = pol_pkg::POS_W'($urandom_range(sb.held + 1, 1));
			else
				pos = pol_pkg::POS_W'($urandom_range(sb.held > 0 ? sb.held : 1, 1));
			send_word(cmd, pos, $urandom, idle_pct);
		end
	endtask

	// stimulus
	initial begin
		arst_n   = 1'b0;
		start    = 1'b0;
		op       = pol_pkg::OP_INSERT;
		position = '0;
		value    = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corners on an empty and a short list
		send_word(pol_pkg::OP_DUMP,   5'd0,  32'sd0, 0);
		send_word(pol_pkg::OP_DELETE, 5'd1,  32'sd0, 0);
		send_word(pol_pkg::OP_INSERT, 5'd0,  32'sd5, 0);
		send_word(pol_pkg::OP_INSERT, 5'd2,  32'sd5, 0);
		send_word(OP_UNUSED,          5'd1,  32'sd7, 0);
		send_word(pol_pkg::OP_INSERT, 5'd1,  32'sh7fffffff, 0);
		send_word(pol_pkg::OP_INSERT, 5'd1,  32'sh80000000, 0);
		send_word(pol_pkg::OP_INSERT, 5'd3,  32'sd0, 0);
		send_word(pol_pkg::OP_INSERT, 5'd2,  -32'sd1, 0);
		send_word(pol_pkg::OP_DUMP,   5'd31, 32'sd0, 0);
		send_word(pol_pkg::OP_DELETE, 5'd0,  32'sd0, 0);
		send_word(pol_pkg::OP_DELETE, 5'd5,  32'sd0, 0);
		send_word(pol_pkg::OP_DELETE, 5'd31, 32'sd0, 0);
		send_word(pol_pkg::OP_INSERT, 5'd31, 32'sh55aa55aa, 0);
		send_word(pol_pkg::OP_DELETE, 5'd4,  32'sd0, 0);
		send_word(pol_pkg::OP_DELETE, 5'd1,  32'sd0, 0);
		send_word(pol_pkg::OP_DUMP,   5'd0,  32'sd0, 0);
		send_word(pol_pkg::OP_DELETE, 5'd1,  32'sd0, 0);
		send_word(pol_pkg::OP_DELETE, 5'd1,  32'sd0, 0);
		send_word(pol_pkg::OP_DUMP,   5'd0,  32'sd0, 0);

		// random phases: no idling, heavy, none, light
		run_random(90, 0);
		run_random(90, 49);
		run_random(90, 0);
		run_random(90, 18);
		start <= 1'b0;

		// drain outstanding words, then allow for stray ones
		while (sb.wanted_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (sb.fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
